// ===== design/thm_pkg.sv =====
// Shared types and constants for the timestamp history matcher.
// Holds the item structs, operation codes and controller state encoding.
// No dependencies.
package thm_pkg;

    localparam int STAMP_W = 64;
    localparam int FIELD_W = 64;
    localparam int WIN_W   = 32;

    // Operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Hold window after reset, in stamp ticks
    localparam logic [WIN_W-1:0] HOLD_WINDOW_RST = 32'd1000000000;

    typedef struct packed {
        logic               operation;
        logic [STAMP_W-1:0] stamp;
        logic [FIELD_W-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [STAMP_W-1:0] match_stamp;
        logic [FIELD_W-1:0] match_payload;
        logic               overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EV_RD,
        ST_EV_CHK,
        ST_Q_RD,
        ST_Q_CHK,
        ST_DONE
    } t_state;

endpackage

// ===== design/timestamp_history_matcher_unit.sv =====
// Timestamp history matcher: DEPTH-record ring, push with age eviction, query
// for the newest record stamped at or before a given time. One item at a time.
// A push writes its record on accept (over the oldest when full, flagging overflow), then
// evicts aged records oldest-first; a query reads newest-first until a match or the end.
// The result is registered as the block goes idle; a waiting output result holds that off.
// Synchronous active-low reset empties the store and sets the hold window.
module timestamp_history_matcher_unit #(
    parameter int DEPTH         = 64,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [thm_pkg::WIN_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  thm_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output thm_pkg::t_out_item        o_out_item
);
    import thm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [STAMP_W-1:0]       mem_wstamp;
    logic [PAYLOAD_WIDTH-1:0] mem_wpayload;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    logic [STAMP_W-1:0]       mem_rstamp;
    logic [PAYLOAD_WIDTH-1:0] mem_rpayload;
    logic                     res_vld;
    t_out_item                res;
    logic                     res_take;
    logic                     r_out_vld;
    t_out_item                r_out;

    thm_ctrl #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_item      (i_in_item),
        .o_in_stall     (o_in_stall),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wstamp   (mem_wstamp),
        .o_mem_wpayload (mem_wpayload),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rstamp   (mem_rstamp),
        .i_mem_rpayload (mem_rpayload),
        .o_res_vld      (res_vld),
        .o_res          (res),
        .i_res_take     (res_take)
    );

    thm_mem #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_we       (mem_we),
        .i_waddr    (mem_waddr),
        .i_wstamp   (mem_wstamp),
        .i_wpayload (mem_wpayload),
        .i_re       (mem_re),
        .i_raddr    (mem_raddr),
        .o_rstamp   (mem_rstamp),
        .o_rpayload (mem_rpayload)
    );

    // output register: load when empty or being drained
    assign res_take = res_vld && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== design/thm_mem.sv =====
// Record store: stamp and payload arrays, one write port, one read port.
// Read data is registered. Uses thm_pkg.
module thm_mem #(
    parameter int DEPTH         = 64,
    parameter int PAYLOAD_WIDTH = 64,
    localparam int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [thm_pkg::STAMP_W-1:0] i_wstamp,
    input  logic [PAYLOAD_WIDTH-1:0]    i_wpayload,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [thm_pkg::STAMP_W-1:0] o_rstamp,
    output logic [PAYLOAD_WIDTH-1:0]    o_rpayload
);
    import thm_pkg::*;

    logic [STAMP_W-1:0]       stamp_mem   [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] payload_mem [DEPTH];
    logic [STAMP_W-1:0]       r_rstamp;
    logic [PAYLOAD_WIDTH-1:0] r_rpayload;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            stamp_mem[i_waddr]   <= i_wstamp;
            payload_mem[i_waddr] <= i_wpayload;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rstamp   <= stamp_mem[i_raddr];
            r_rpayload <= payload_mem[i_raddr];
        end
    end

    assign o_rstamp   = r_rstamp;
    assign o_rpayload = r_rpayload;

endmodule

// ===== design/thm_ctrl.sv =====
// Sequencer for push/evict and newest-first query walks over the record store.
// Owns ring pointer, fill count and hold window. Uses thm_pkg.
module thm_ctrl #(
    parameter int DEPTH         = 64,
    parameter int PAYLOAD_WIDTH = 64,
    localparam int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW           = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [thm_pkg::WIN_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    input  thm_pkg::t_in_item           i_in_item,
    output logic                        o_in_stall,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [thm_pkg::STAMP_W-1:0] o_mem_wstamp,
    output logic [PAYLOAD_WIDTH-1:0]    o_mem_wpayload,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [thm_pkg::STAMP_W-1:0] i_mem_rstamp,
    input  logic [PAYLOAD_WIDTH-1:0]    i_mem_rpayload,
    output logic                        o_res_vld,
    output thm_pkg::t_out_item          o_res,
    input  logic                        i_res_take
);
    import thm_pkg::*;

    localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL    = CW'(DEPTH);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_oldest, n_oldest;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_k, n_k;
    logic [WIN_W-1:0]   r_window;
    logic [STAMP_W-1:0] r_key, n_key;
    t_out_item          r_res, n_res;

    logic               accept;
    logic               is_full;
    logic [AW-1:0]      oldest_inc;
    logic [STAMP_W-1:0] limit;
    logic               below;
    logic               match;
    logic [FIELD_W-1:0] payload_ext;

    // ring index add with wrap; both operands below DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    assign accept     = (r_state == ST_IDLE) && i_in_valid;
    assign is_full    = (r_count == FULL);
    assign oldest_inc = (r_oldest == LAST) ? '0 : r_oldest + 1'b1;

    // eviction threshold, saturating at zero
    assign limit = (i_in_item.stamp > {{(STAMP_W-WIN_W){1'b0}}, r_window})
                 ? i_in_item.stamp - {{(STAMP_W-WIN_W){1'b0}}, r_window}
                 : '0;

    assign below = (i_mem_rstamp < r_key);
    assign match = (i_mem_rstamp <= r_key);

    always_comb begin
        payload_ext = '0;
        payload_ext[PAYLOAD_WIDTH-1:0] = i_mem_rpayload;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_in_item.operation == OP_PUSH) ? ST_EV_RD : ST_Q_RD;
                end
            end
            ST_EV_RD:  n_state = (r_count == '0) ? ST_DONE : ST_EV_CHK;
            ST_EV_CHK: n_state = below ? ST_EV_RD : ST_DONE;
            ST_Q_RD:   n_state = (r_k == '0) ? ST_DONE : ST_Q_CHK;
            ST_Q_CHK:  n_state = match ? ST_DONE : ST_Q_RD;
            ST_DONE:   n_state = i_res_take ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_oldest = r_oldest;
        n_count  = r_count;
        n_k      = r_k;
        n_key    = r_key;
        n_res    = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    if (i_in_item.operation == OP_PUSH) begin
                        n_key = limit;
                        if (is_full) begin
                            // drop oldest, append in its slot; count stays full
                            n_oldest         = oldest_inc;
                            n_res.overflow   = 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_key = i_in_item.stamp;
                        n_k   = r_count;
                    end
                end
            end
            ST_EV_CHK: begin
                if (below) begin
                    n_oldest = oldest_inc;
                    n_count  = r_count - 1'b1;
                end
            end
            ST_Q_CHK: begin
                if (match) begin
                    n_res.found         = 1'b1;
                    n_res.match_stamp   = i_mem_rstamp;
                    n_res.match_payload = payload_ext;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // outputs: handshake, memory strobes
    always_comb begin
        o_in_stall     = (r_state != ST_IDLE);
        o_res_vld      = (r_state == ST_DONE);
        o_mem_we       = accept && (i_in_item.operation == OP_PUSH);
        o_mem_waddr    = is_full ? r_oldest : wrap_add(r_oldest, AW'(r_count));
        o_mem_wstamp   = i_in_item.stamp;
        o_mem_wpayload = i_in_item.payload[PAYLOAD_WIDTH-1:0];
        o_mem_re       = ((r_state == ST_EV_RD) && (r_count != '0))
                      || ((r_state == ST_Q_RD) && (r_k != '0));
        o_mem_raddr    = (r_state == ST_EV_RD) ? r_oldest
                                               : wrap_add(r_oldest, AW'(r_k - 1'b1));
    end

    assign o_res = r_res;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_window <= HOLD_WINDOW_RST;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_key <= n_key;
        r_res <= n_res;
    end

endmodule

// ===== design/thm_checker.sv =====
// Port-level checks for the timestamp history matcher, bound to the top level.
// Depends on thm_pkg and timestamp_history_matcher_unit.
module thm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input thm_pkg::t_in_item   i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input thm_pkg::t_out_item  o_out_item
);
    import thm_pkg::*;

    // no result leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a result never flags both a query match and a push overflow
    a_found_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.found && o_out_item.overflow))
        else $error("found and overflow both set");

    // without a match the match fields are zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found)
            |-> (o_out_item.match_stamp == '0) && (o_out_item.match_payload == '0))
        else $error("match fields nonzero without a match");

    // the block works on one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted back to back");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind timestamp_history_matcher_unit thm_checker u_thm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
